[design/uhs_pkg.sv]
package uhs_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_W         = 16;
    localparam int SQRT_W           = 17;
    localparam int RAD_W            = 34;
    localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;

    typedef struct packed {
        logic [15:0] cos_sample;
        logic [15:0] azimuth_sample;
    } uhs_in_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic [15:0]        dir_y;
        logic signed [15:0] dir_z;
    } uhs_out_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] r;
        begin
            case (idx)
                0:  r = 32'h20000000;
                1:  r = 32'h12E4051E;
                2:  r = 32'h09FB385B;
                3:  r = 32'h051111D4;
                4:  r = 32'h028B0D43;
                5:  r = 32'h0145D7E1;
                6:  r = 32'h00A2F61E;
                7:  r = 32'h00517C55;
                8:  r = 32'h0028BE53;
                9:  r = 32'h00145F2F;
                10: r = 32'h000A2F98;
                11: r = 32'h000517CC;
                12: r = 32'h00028BE6;
                13: r = 32'h000145F3;
                14: r = 32'h0000A2F9;
                15: r = 32'h0000517C;
                16: r = 32'h000028BE;
                17: r = 32'h0000145F;
                18: r = 32'h00000A2F;
                19: r = 32'h00000517;
                20: r = 32'h0000028B;
                21: r = 32'h00000145;
                22: r = 32'h000000A2;
                23: r = 32'h00000051;
                24: r = 32'h00000028;
                25: r = 32'h00000014;
                26: r = 32'h0000000A;
                27: r = 32'h00000005;
                28: r = 32'h00000002;
                29: r = 32'h00000001;
                default: r = 32'h00000000;
            endcase
            return r;
        end
    endfunction

endpackage

[design/uhs_sqrt.sv]
// Pipelined restoring square root: one result bit per stage, SQRT_W stages.
// Side data rides along with each stage; all stages advance on adv.
module uhs_sqrt #(
    parameter int SIDE_W = 32
) (
    input  logic                   aclk,
    input  logic                   adv,
    input  logic [uhs_pkg::RAD_W-1:0] radicand,
    input  logic [SIDE_W-1:0]      side_in,
    output logic [uhs_pkg::SQRT_W-1:0] root,
    output logic [SIDE_W-1:0]      side_out
);
    import uhs_pkg::*;

    localparam int N  = SQRT_W;
    localparam int RW = SQRT_W + 2;

    logic [RAD_W-1:0]  rad_reg  [N+1];
    logic [RW-1:0]     rem_reg  [N+1];
    logic [N-1:0]      q_reg    [N+1];
    logic [SIDE_W-1:0] side_reg [N+1];

    always_comb begin
        rad_reg[0]  = radicand;
        rem_reg[0]  = '0;
        q_reg[0]    = '0;
        side_reg[0] = side_in;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [RW-1:0] rem_next;
        logic [RW-1:0] trial;
        always_comb begin
            rem_next = {rem_reg[k][RW-3:0], rad_reg[k][RAD_W-1 -: 2]};
            trial    = {q_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k+1]  <= {rad_reg[k][RAD_W-3:0], 2'b00};
                side_reg[k+1] <= side_reg[k];
                if (rem_next >= trial) begin
                    rem_reg[k+1] <= rem_next - trial;
                    q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= rem_next;
                    q_reg[k+1]   <= {q_reg[k][N-2:0], 1'b0};
                end
            end
        end
    end

    assign root     = q_reg[N];
    assign side_out = side_reg[N];

endmodule

[design/uhs_cordic.sv]
// Rotation-mode CORDIC, one micro-rotation per register stage.
module uhs_cordic #(
    parameter int FRAC_BITS    = uhs_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = uhs_pkg::CORDIC_STEPS_DEF,
    parameter int SIDE_W       = 16
) (
    input  logic                     aclk,
    input  logic                     adv,
    input  logic signed [FRAC_BITS+2:0] x_in,
    input  logic signed [32:0]       z_in,
    input  logic [SIDE_W-1:0]        side_in,
    output logic signed [FRAC_BITS+2:0] x_out,
    output logic signed [FRAC_BITS+2:0] y_out,
    output logic [SIDE_W-1:0]        side_out
);
    import uhs_pkg::*;

    localparam int VW = FRAC_BITS + 3;
    localparam int N  = CORDIC_STEPS;

    logic signed [VW-1:0] x_reg [N+1];
    logic signed [VW-1:0] y_reg [N+1];
    logic signed [32:0]   z_reg [N+1];
    logic [SIDE_W-1:0]    s_reg [N+1];

    always_comb begin
        x_reg[0] = x_in;
        y_reg[0] = '0;
        z_reg[0] = z_in;
        s_reg[0] = side_in;
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam int SH = (i < VW) ? i : VW - 1;
        localparam logic signed [32:0] ANG = $signed({1'b0, atan_turn(i)});
        logic signed [VW-1:0] dx, dy;
        always_comb begin
            dx = y_reg[i] >>> SH;
            dy = x_reg[i] >>> SH;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                s_reg[i+1] <= s_reg[i];
                if (!z_reg[i][32]) begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ANG;
                end else begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
            end
        end
    end

    assign x_out    = x_reg[N];
    assign y_out    = y_reg[N];
    assign side_out = s_reg[N];

endmodule

[design/uniform_hemisphere_sampler_unit.sv]
// Pipeline: 17 + 1 + CORDIC_STEPS + 1 register stages (square root stages, gain multiply,
// CORDIC stages, output register fed by the quadrant fix and rounding).
// Throughput: one item per cycle; the whole pipeline advances whenever the
// output register is empty or being taken, so a stall freezes every stage.
// Reset: aresetn (synchronous, active low) clears all valid bits.
module uniform_hemisphere_sampler_unit #(
    parameter int FRAC_BITS    = uhs_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = uhs_pkg::CORDIC_STEPS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  uhs_pkg::uhs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output uhs_pkg::uhs_out_t m_data
);
    import uhs_pkg::*;

    localparam int VW    = FRAC_BITS + 3;
    localparam int DEPTH = SQRT_W + 1 + CORDIC_STEPS;
    localparam int SH    = FRAC_BITS - 15;
    localparam int PW    = VW + 16;

    logic [DEPTH-1:0] vld_reg;
    logic             adv;
    uhs_out_t         out_reg;
    logic             out_vld_reg;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[DEPTH-2:0], s_valid};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // Square root of 2^32 - u1^2; the squaring is folded in ahead of stage one.
    logic [RAD_W-1:0] rad;
    logic [SQRT_W-1:0] sine;
    logic [31:0]       sq_side;
    assign rad = (RAD_W'(1) << 32) - RAD_W'(s_data.cos_sample * s_data.cos_sample);

    uhs_sqrt #(.SIDE_W(32)) u_sqrt (
        .aclk(aclk), .adv(adv), .radicand(rad),
        .side_in({s_data.cos_sample, s_data.azimuth_sample}),
        .root(sine), .side_out(sq_side)
    );

    // Gain multiply and angle reduction.
    logic [48:0]          gprod;
    logic signed [VW-1:0] x0_reg;
    logic signed [32:0]   z0_reg;
    logic [17:0]          g_side_reg;
    logic [31:0]          angle;
    logic [1:0]           quarter;
    logic [31:0]          resid;

    always_comb begin
        gprod   = 49'(GAIN_Q32) * 49'(sine);
        angle   = {sq_side[15:0], 16'h0000};
        quarter = 2'((angle + 32'h20000000) >> 30);
        resid   = angle - {quarter, 30'd0};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x0_reg     <= $signed(VW'(gprod >> (48 - FRAC_BITS)));
            z0_reg     <= $signed({resid[31], resid});
            g_side_reg <= {sq_side[31:16], quarter};
        end
    end

    logic signed [VW-1:0] cx, cy;
    logic [17:0]          c_side;

    uhs_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS), .SIDE_W(18)) u_cordic (
        .aclk(aclk), .adv(adv), .x_in(x0_reg), .z_in(z0_reg), .side_in(g_side_reg),
        .x_out(cx), .y_out(cy), .side_out(c_side)
    );

    function automatic logic signed [15:0] to_q15(input logic signed [VW:0] v);
        logic signed [PW-1:0] w;
        begin
            if (SH > 0) w = (PW'(v) + (PW'(1) << (SH > 0 ? SH - 1 : 0))) >>> (SH > 0 ? SH : 0);
            else        w = PW'(v) <<< (SH < 0 ? -SH : 0);
            if (w > PW'(32767))       return 16'sd32767;
            else if (w < -PW'(32768)) return -16'sd32768;
            else                      return w[15:0];
        end
    endfunction

    logic signed [VW:0] qx, qz;
    always_comb begin
        case (c_side[1:0])
            2'd1:    begin qx = -(VW+1)'(cy); qz =  (VW+1)'(cx); end
            2'd2:    begin qx = -(VW+1)'(cx); qz = -(VW+1)'(cy); end
            2'd3:    begin qx =  (VW+1)'(cy); qz = -(VW+1)'(cx); end
            default: begin qx =  (VW+1)'(cx); qz =  (VW+1)'(cy); end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg.dir_x <= to_q15(qx);
            out_reg.dir_y <= c_side[17:2];
            out_reg.dir_z <= to_q15(qz);
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule
